// ===== rtl/ulst_pkg.sv =====
// Shared types, constants and codes for the unordered list table.
package ulst_pkg;

    localparam int DEPTH      = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_SEARCH = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_REWIND = 3'd4,
        KIND_READ   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PAST_END  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;       // latch a new beat, arm the scan
        logic exec;        // insert, clear and rewind operations, read issue
        logic rd_capture;  // take read data as the result item
        logic scan;        // walk entries, one per cycle
        logic move_rd;     // read the last entry
        logic move_wr;     // overwrite the matched slot, drop the count
        logic load_out;    // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  read_ok;
        logic  hit;
        logic  miss;
        logic  out_free;
    } dp_sts_t;

endpackage

// ===== rtl/ulst_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ulst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ulst_dp.sv =====
// Datapath: table memory, count, cursor, scan pipeline and result registers.
module ulst_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ulst_pkg::dp_cmd_t                   cmd,
    output ulst_pkg::dp_sts_t                   sts,
    input  logic [2:0]                          s_kind,
    input  logic [ulst_pkg::ITEM_WIDTH-1:0]     s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [ulst_pkg::ITEM_WIDTH-1:0]     m_item_out,
    output logic [ulst_pkg::CNT_W-1:0]          m_entry_count,
    output logic                                m_is_full,
    output logic                                m_cursor_at_end
);

    localparam int AW = ulst_pkg::ADDR_W;
    localparam int CW = ulst_pkg::CNT_W;
    localparam int IW = ulst_pkg::ITEM_WIDTH;

    // control state
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] idx_reg,    idx_next;
    logic          pend_vld_reg, pend_vld_next;
    logic          m_valid_reg,  m_valid_next;

    // payload
    ulst_pkg::kind_t   kind_reg,  kind_next;
    logic [IW-1:0]     val_reg,   val_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic [AW-1:0]     pos_reg,   pos_next;
    ulst_pkg::status_t res_status_reg, res_status_next;
    logic [IW-1:0]     res_item_reg,   res_item_next;
    logic [1:0]        m_status_reg,   m_status_next;
    logic [IW-1:0]     m_item_reg,     m_item_next;
    logic [CW-1:0]     m_count_reg,    m_count_next;
    logic              m_full_reg,     m_full_next;
    logic              m_end_reg,      m_end_next;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    logic read_ok;
    logic hit;
    logic miss;
    logic out_free;

    ulst_ram #(
        .WIDTH (IW),
        .DEPTH (ulst_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign read_ok  = (cursor_reg < count_reg);
    assign hit      = pend_vld_reg && (ram_rdata == val_reg);
    assign miss     = !pend_vld_reg && (idx_reg >= count_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign sts.kind     = kind_reg;
    assign sts.read_ok  = read_ok;
    assign sts.hit      = hit;
    assign sts.miss     = miss;
    assign sts.out_free = out_free;

    always_comb begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        idx_next        = idx_reg;
        pend_vld_next   = pend_vld_reg;
        m_valid_next    = m_valid_reg;
        kind_next       = kind_reg;
        val_next        = val_reg;
        pend_idx_next   = pend_idx_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_item_next   = res_item_reg;
        m_status_next   = m_status_reg;
        m_item_next     = m_item_reg;
        m_count_next    = m_count_reg;
        m_full_next     = m_full_reg;
        m_end_next      = m_end_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = val_reg;
        ram_raddr       = idx_reg[AW-1:0];

        if (cmd.start) begin
            kind_next       = ulst_pkg::kind_t'(s_kind);
            val_next        = s_item_value;
            idx_next        = '0;
            pend_vld_next   = 1'b0;
            res_status_next = ulst_pkg::ST_OK;
            res_item_next   = '0;
        end

        if (cmd.exec) begin
            case (kind_reg)
                ulst_pkg::KIND_INSERT: begin
                    if (count_reg < CW'(ulst_pkg::DEPTH)) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        res_status_next = ulst_pkg::ST_FULL;
                    end
                end
                ulst_pkg::KIND_CLEAR:  count_next  = '0;
                ulst_pkg::KIND_REWIND: cursor_next = '0;
                ulst_pkg::KIND_READ: begin
                    if (read_ok) begin
                        ram_raddr   = cursor_reg[AW-1:0];
                        cursor_next = cursor_reg + CW'(1);
                    end else begin
                        res_status_next = ulst_pkg::ST_PAST_END;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.rd_capture) begin
            res_item_next = ram_rdata;
        end

        if (cmd.scan) begin
            // issue one read per cycle, compare its data in the following cycle
            if (idx_reg < count_reg) begin
                ram_raddr     = idx_reg[AW-1:0];
                idx_next      = idx_reg + CW'(1);
                pend_vld_next = 1'b1;
                pend_idx_next = idx_reg[AW-1:0];
            end else begin
                pend_vld_next = 1'b0;
            end
            if (hit) begin
                pos_next = pend_idx_reg;
                if (kind_reg == ulst_pkg::KIND_SEARCH) begin
                    res_item_next = ram_rdata;
                end
            end else if (miss) begin
                res_status_next = ulst_pkg::ST_NOT_FOUND;
            end
        end

        if (cmd.move_rd) begin
            ram_raddr = AW'(count_reg - CW'(1));
        end

        if (cmd.move_wr) begin
            ram_we     = 1'b1;
            ram_waddr  = pos_reg;
            ram_wdata  = ram_rdata;
            count_next = count_reg - CW'(1);
        end

        if (cmd.load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_item_next   = res_item_reg;
            m_count_next  = count_reg;
            m_full_next   = (count_reg == CW'(ulst_pkg::DEPTH));
            m_end_next    = (cursor_reg == count_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cursor_reg   <= '0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            idx_reg      <= idx_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        val_reg        <= val_next;
        pend_idx_reg   <= pend_idx_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_item_reg   <= res_item_next;
        m_status_reg   <= m_status_next;
        m_item_reg     <= m_item_next;
        m_count_reg    <= m_count_next;
        m_full_reg     <= m_full_next;
        m_end_reg      <= m_end_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_item_out      = m_item_reg;
    assign m_entry_count   = m_count_reg;
    assign m_is_full       = m_full_reg;
    assign m_cursor_at_end = m_end_reg;

endmodule

// ===== rtl/ulst_ctrl.sv =====
// Controller state machine sequencing each operation.
module ulst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  ulst_pkg::kind_t   s_kind,
    output logic              s_ready,
    input  ulst_pkg::dp_sts_t sts,
    output ulst_pkg::dp_cmd_t cmd
);

    ulst_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ulst_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_kind == ulst_pkg::KIND_DELETE || s_kind == ulst_pkg::KIND_SEARCH) begin
                        state_next = ulst_pkg::S_SCAN;
                    end else begin
                        state_next = ulst_pkg::S_EXEC;
                    end
                end
            end
            ulst_pkg::S_EXEC: begin
                if (sts.kind == ulst_pkg::KIND_READ && sts.read_ok) begin
                    state_next = ulst_pkg::S_RDWAIT;
                end else begin
                    state_next = ulst_pkg::S_EMIT;
                end
            end
            ulst_pkg::S_RDWAIT: state_next = ulst_pkg::S_EMIT;
            ulst_pkg::S_SCAN: begin
                if (sts.hit) begin
                    if (sts.kind == ulst_pkg::KIND_DELETE) begin
                        state_next = ulst_pkg::S_MOVE_RD;
                    end else begin
                        state_next = ulst_pkg::S_EMIT;
                    end
                end else if (sts.miss) begin
                    state_next = ulst_pkg::S_EMIT;
                end
            end
            ulst_pkg::S_MOVE_RD: state_next = ulst_pkg::S_MOVE_WR;
            ulst_pkg::S_MOVE_WR: state_next = ulst_pkg::S_EMIT;
            ulst_pkg::S_EMIT: begin
                if (sts.out_free) begin
                    state_next = ulst_pkg::S_IDLE;
                end
            end
            default: state_next = ulst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ulst_pkg::S_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ulst_pkg::S_EXEC:    cmd.exec       = 1'b1;
            ulst_pkg::S_RDWAIT:  cmd.rd_capture = 1'b1;
            ulst_pkg::S_SCAN:    cmd.scan       = 1'b1;
            ulst_pkg::S_MOVE_RD: cmd.move_rd    = 1'b1;
            ulst_pkg::S_MOVE_WR: cmd.move_wr    = 1'b1;
            ulst_pkg::S_EMIT:    cmd.load_out   = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ulst_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/unordered_list_table.sv =====
// Steps from accept to result: exec then emit for insert, clear, rewind and unused kinds,
// exec, read wait and emit for read next, scan then emit for search, scan, move and emit for delete.
// The delete/search time is set by the scan over the single table memory read port,
// one entry per cycle. One beat is in work at a time; the next beat is taken once
// its result has moved to the output register, which holds it until taken.
// Reset (aresetn, synchronous, active low) zeroes count and cursor; table memory is not cleared.
module unordered_list_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_kind,
    input  logic [ulst_pkg::ITEM_WIDTH-1:0] s_item_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [ulst_pkg::ITEM_WIDTH-1:0] m_item_out,
    output logic [ulst_pkg::CNT_W-1:0]      m_entry_count,
    output logic                            m_is_full,
    output logic                            m_cursor_at_end
);

    // command and status between the controller and the datapath
    ulst_pkg::dp_cmd_t cmd;
    ulst_pkg::dp_sts_t sts;

    // Controller: takes the input beat, steps through exec, scan and move,
    // then holds in emit until the output register is free.
    ulst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (ulst_pkg::kind_t'(s_kind)),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: table memory, count, cursor, scan pipeline and output register.
    ulst_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_kind          (s_kind),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_item_out      (m_item_out),
        .m_entry_count   (m_entry_count),
        .m_is_full       (m_is_full),
        .m_cursor_at_end (m_cursor_at_end)
    );

`ifndef SYNTHESIS
    // a taken beat closes the input until its result has been handed off
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a beat is in work");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.load_out)
        else $error("output register overwritten while stalled");

    // datapath phases never overlap
    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.start, cmd.exec, cmd.rd_capture, cmd.scan,
                  cmd.move_rd, cmd.move_wr, cmd.load_out}))
        else $error("overlapping datapath commands");

    // a scan never reports hit and miss together
    a_hit_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> !(sts.hit && sts.miss))
        else $error("scan hit and miss at once");
`endif

endmodule
